>>> hdl/assert_macros.svh
// Assertion macros used by the decoder core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Implication checked in the same cycle outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> hdl/sfd_pkg.sv
// Package: constants and result type of the septet serial frame decoder.
`default_nettype none

package sfd_pkg;

    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [6:0] PROTO_V1    = 7'h10;
    localparam logic [6:0] PROTO_V2    = 7'h20;
    localparam logic [6:0] CSUM_TARGET = 7'h7F;

    localparam logic [2:0] KIND_FRAME     = 3'd0;
    localparam logic [2:0] KIND_EMPTY     = 3'd1;
    localparam logic [2:0] KIND_DATAGRAM  = 3'd2;
    localparam logic [2:0] KIND_HDR_ERR   = 3'd3;
    localparam logic [2:0] KIND_FRAME_ERR = 3'd4;

    typedef struct packed {
        logic [2:0]  result_kind;
        logic [14:0] dest_addr;
        logic [14:0] source_addr;
        logic [6:0]  protocol_code;
        logic [14:0] command_code;
        logic [15:0] item_id;
        logic [31:0] data_value;
        logic [6:0]  frame_index;
        logic        last_frame;
    } t_result;

endpackage

`default_nettype wire

>>> hdl/sfd_parser.sv
// Byte-level message parser: header and frame state, checksums, result decode.
`default_nettype none

module sfd_parser (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_step,
    input  wire logic [7:0]      i_rx_byte,
    output logic                 o_emit,
    output sfd_pkg::t_result     o_result
);
    import sfd_pkg::*;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_HDR  = 2'd1;
    localparam logic [1:0] MODE_FRM  = 2'd2;

    localparam int HDR_KEEP = 14;
    localparam int FRM_KEEP = 5;

    logic [1:0] r_mode, n_mode;
    logic [6:0] r_hdr [HDR_KEEP];
    logic [6:0] n_hdr [HDR_KEEP];
    logic [3:0] r_hdr_cnt, n_hdr_cnt;
    logic [6:0] r_hdr_sum, n_hdr_sum;
    logic [6:0] r_frm [FRM_KEEP];
    logic [6:0] n_frm [FRM_KEEP];
    logic [2:0] r_frm_cnt, n_frm_cnt;
    logic [6:0] r_frm_sum, n_frm_sum;
    logic [6:0] r_frames_total, n_frames_total;
    logic [6:0] r_frames_done, n_frames_done;

    logic [6:0]  w_data;
    logic [6:0]  w_hdr_sum_nx;
    logic [6:0]  w_frm_sum_nx;
    logic [6:0]  w_done_nx;
    logic        w_last;
    logic [15:0] w_dg_id;
    logic [31:0] w_dg_value;
    logic [31:0] w_frm_value;

    assign w_data       = i_rx_byte[6:0];
    assign w_hdr_sum_nx = r_hdr_sum + w_data;
    assign w_frm_sum_nx = r_frm_sum + w_data;
    assign w_done_nx    = r_frames_done + 7'd1;
    assign w_last       = (w_done_nx >= r_frames_total);

    assign w_dg_id    = {r_hdr[13][1], r_hdr[8], r_hdr[13][0], r_hdr[7]};
    assign w_dg_value = {r_hdr[13][5], r_hdr[12], r_hdr[13][4], r_hdr[11],
                         r_hdr[13][3], r_hdr[10], r_hdr[13][2], r_hdr[9]};
    assign w_frm_value = {r_frm[4][3], r_frm[3], r_frm[4][2], r_frm[2],
                          r_frm[4][1], r_frm[1], r_frm[4][0], r_frm[0]};

    always_comb begin
        n_mode         = r_mode;
        n_hdr          = r_hdr;
        n_hdr_cnt      = r_hdr_cnt;
        n_hdr_sum      = r_hdr_sum;
        n_frm          = r_frm;
        n_frm_cnt      = r_frm_cnt;
        n_frm_sum      = r_frm_sum;
        n_frames_total = r_frames_total;
        n_frames_done  = r_frames_done;

        o_emit                 = 1'b0;
        o_result.result_kind   = KIND_FRAME;
        o_result.dest_addr     = {r_hdr[1], 1'b0, r_hdr[0]};
        o_result.source_addr   = {r_hdr[3], 1'b0, r_hdr[2]};
        o_result.protocol_code = r_hdr[4];
        o_result.command_code  = {r_hdr[6], 1'b0, r_hdr[5]};
        o_result.item_id       = '0;
        o_result.data_value    = '0;
        o_result.frame_index   = '0;
        o_result.last_frame    = 1'b0;

        if (i_step) begin
            if (i_rx_byte == SYNC_BYTE) begin
                n_mode    = MODE_HDR;
                n_hdr_cnt = '0;
                n_hdr_sum = '0;
            end else if (i_rx_byte[7]) begin
                n_mode = MODE_IDLE;
            end else begin
                unique case (r_mode)
                    MODE_HDR: begin
                        if (r_hdr_cnt != 4'd15) begin
                            if (r_hdr_cnt < 4'(HDR_KEEP)) begin
                                n_hdr[r_hdr_cnt] = w_data;
                            end
                            n_hdr_cnt = r_hdr_cnt + 4'd1;
                            n_hdr_sum = w_hdr_sum_nx;
                            if (r_hdr_cnt == 4'd14 && r_hdr[4] == PROTO_V2) begin
                                n_mode = MODE_IDLE;
                                o_emit = 1'b1;
                                if (w_hdr_sum_nx == CSUM_TARGET) begin
                                    o_result.result_kind = KIND_DATAGRAM;
                                    o_result.item_id     = w_dg_id;
                                    o_result.data_value  = w_dg_value;
                                end else begin
                                    o_result.result_kind = KIND_HDR_ERR;
                                end
                            end else if (r_hdr_cnt == 4'd8 && r_hdr[4] == PROTO_V1) begin
                                if (w_hdr_sum_nx != CSUM_TARGET) begin
                                    n_mode               = MODE_IDLE;
                                    o_emit               = 1'b1;
                                    o_result.result_kind = KIND_HDR_ERR;
                                end else if (r_hdr[7] != 7'd0) begin
                                    n_mode         = MODE_FRM;
                                    n_frames_total = r_hdr[7];
                                    n_frames_done  = '0;
                                    n_frm_cnt      = '0;
                                    n_frm_sum      = '0;
                                end else begin
                                    n_mode               = MODE_IDLE;
                                    o_emit               = 1'b1;
                                    o_result.result_kind = KIND_EMPTY;
                                end
                            end
                        end
                    end
                    MODE_FRM: begin
                        if (r_frm_cnt == 3'(FRM_KEEP)) begin
                            n_frm_cnt = '0;
                            n_frm_sum = '0;
                            o_emit    = 1'b1;
                            o_result.frame_index = r_frames_done;
                            if (w_frm_sum_nx == CSUM_TARGET) begin
                                n_frames_done        = w_done_nx;
                                o_result.result_kind = KIND_FRAME;
                                o_result.data_value  = w_frm_value;
                                o_result.last_frame  = w_last;
                                if (w_last) begin
                                    n_mode = MODE_IDLE;
                                end
                            end else begin
                                o_result.result_kind = KIND_FRAME_ERR;
                            end
                        end else begin
                            n_frm[r_frm_cnt] = w_data;
                            n_frm_cnt        = r_frm_cnt + 3'd1;
                            n_frm_sum        = w_frm_sum_nx;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_IDLE;
            r_hdr_cnt      <= '0;
            r_hdr_sum      <= '0;
            r_frm_cnt      <= '0;
            r_frm_sum      <= '0;
            r_frames_total <= '0;
            r_frames_done  <= '0;
        end else begin
            r_mode         <= n_mode;
            r_hdr_cnt      <= n_hdr_cnt;
            r_hdr_sum      <= n_hdr_sum;
            r_frm_cnt      <= n_frm_cnt;
            r_frm_sum      <= n_frm_sum;
            r_frames_total <= n_frames_total;
            r_frames_done  <= n_frames_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        r_frm <= n_frm;
    end

endmodule

`default_nettype wire

>>> hdl/septet_serial_frame_decoder_core.sv
// Septet serial frame decoder: byte input stage, parser and result register.
//
// Input channel: one received serial byte per transaction on i_rx_byte,
// i_valid / o_stall. Byte 0xAA starts a message, any other byte with bit 7
// set aborts it. Output channel: one decoded result per transaction,
// o_valid / i_stall; a message byte yields zero or one result.
// Path: the byte is registered in the input register, and the parser decodes
// it straight into the result register, which drives o_valid.
// Throughput: one byte per cycle while the receiver does not stall with a
// result held; the parser handles each byte with running 7-bit checksums.
// While the receiver stalls with a result held, the parser pauses: a byte
// waiting in the input register is not decoded, whether it would yield a
// result or not, and o_stall stays high until the held result is taken.
// Reset (synchronous, active low) returns the parser to idle, waiting for a
// sync byte, and empties both registers.
`default_nettype none
`include "assert_macros.svh"

module septet_serial_frame_decoder_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_rx_byte,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [2:0]       o_result_kind,
    output logic [14:0]      o_dest_addr,
    output logic [14:0]      o_source_addr,
    output logic [6:0]       o_protocol_code,
    output logic [14:0]      o_command_code,
    output logic [15:0]      o_item_id,
    output logic [31:0]      o_data_value,
    output logic [6:0]       o_frame_index,
    output logic             o_last_frame
);
    import sfd_pkg::*;

    logic       r_in_valid, n_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid, n_out_valid;
    t_result    r_out;
    t_result    w_result;
    logic       w_emit;
    logic       w_fire;
    logic       w_in_take;

    assign w_fire    = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !w_fire;
    assign w_in_take = i_valid && !o_stall;

    sfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_fire),
        .i_rx_byte (r_in_byte),
        .o_emit    (w_emit),
        .o_result  (w_result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_in_take) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (w_fire) begin
            n_out_valid = w_emit;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx_byte;
        end
        if (w_fire && w_emit) begin
            r_out <= w_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_kind   = r_out.result_kind;
    assign o_dest_addr     = r_out.dest_addr;
    assign o_source_addr   = r_out.source_addr;
    assign o_protocol_code = r_out.protocol_code;
    assign o_command_code  = r_out.command_code;
    assign o_item_id       = r_out.item_id;
    assign o_data_value    = r_out.data_value;
    assign o_frame_index   = r_out.frame_index;
    assign o_last_frame    = r_out.last_frame;

    `ASSERT_RST(a_byte_kept, i_clk, i_rst_n, r_in_valid && !w_fire |=> r_in_valid,
        "pending byte lost")
    `ASSERT_IMPL(a_kind_range, i_clk, i_rst_n, o_valid,
        o_result_kind <= KIND_FRAME_ERR, "bad result kind")
    `ASSERT_IMPL(a_last_is_frame, i_clk, i_rst_n, o_valid && o_last_frame,
        o_result_kind == KIND_FRAME, "last flag on non-frame result")
    `ASSERT_IMPL(a_id_only_v2, i_clk, i_rst_n, o_valid && o_result_kind != KIND_DATAGRAM,
        o_item_id == 16'd0, "item id outside datagram")

endmodule

`default_nettype wire
